>>> rtl/phong_pkg.sv
package phong_pkg;

   localparam int unsigned COORD_W  = 16;
   localparam int unsigned DIR_W    = 16;
   localparam int unsigned LV_W     = COORD_W + 1;
   localparam int unsigned ROOT_W   = LV_W;
   localparam int unsigned RAD_W    = 2 * ROOT_W;
   localparam int unsigned RECIP_W  = 33;
   localparam int unsigned COLOR_W  = 24;
   localparam int unsigned CHAN_W   = 9;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned ONE_Q14  = 16384;
   localparam int unsigned SPEC_SQUARINGS = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_Z  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AMBIENT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIFFUSE  = 3'd4;

   localparam logic [COORD_W-1:0] LIGHT_X_RST = 16'sd0;
   localparam logic [COORD_W-1:0] LIGHT_Y_RST = 16'sd7782;
   localparam logic [COORD_W-1:0] LIGHT_Z_RST = 16'sd0;
   localparam logic [7:0]         AMBIENT_RST = 8'd51;
   localparam logic [7:0]         DIFFUSE_RST = 8'd154;

   // word fields that ride along the sqrt and reciprocal pipes
   typedef struct packed {
      logic [2:0][LV_W-1:0]  lv;
      logic [2:0][DIR_W-1:0] n;
      logic [2:0][DIR_W-1:0] v;
      logic [COLOR_W-1:0]    rgb;
      logic [7:0]            sw;
   } side_type;

   // x / 2^sh, rounded half away from zero
   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x,
                                                    input int unsigned sh);
      logic [63:0] m;
      m = x[63] ? 64'(-x) : 64'(x);
      m = (m + (64'd1 << (sh - 1))) >> sh;
      return x[63] ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [63:0] clamp(input logic signed [63:0] x,
                                                input logic signed [63:0] lo,
                                                input logic signed [63:0] hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
   endfunction

endpackage

>>> rtl/phong_sqrt.sv
module phong_sqrt
   import phong_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [RAD_W-1:0]  in_radicand,
   input  side_type          in_side,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output side_type          out_side
);

   // one root bit per stage, restoring digit recurrence
   logic [RAD_W-1:0]  rad_s  [0:ROOT_W];
   logic [ROOT_W+2:0] rem_s  [0:ROOT_W];
   logic [ROOT_W-1:0] root_s [0:ROOT_W];
   logic              vld_s  [0:ROOT_W];
   side_type          side_s [0:ROOT_W];

   assign rad_s[0]  = in_radicand;
   assign rem_s[0]  = '0;
   assign root_s[0] = '0;
   assign vld_s[0]  = in_valid;
   assign side_s[0] = in_side;

   for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
      logic [RAD_W-1:0]  rad_ff, rad_in;
      logic [ROOT_W+2:0] rem_ff, rem_in, cur, trial;
      logic [ROOT_W-1:0] root_ff, root_in;
      logic              vld_ff;
      side_type          side_ff;

      always_comb begin
         cur   = {rem_s[g][ROOT_W:0], rad_s[g][RAD_W-1 -: 2]};
         trial = {1'b0, root_s[g], 2'b01};
         rad_in = {rad_s[g][RAD_W-3:0], 2'b00};
         if (cur >= trial) begin
            rem_in  = cur - trial;
            root_in = {root_s[g][ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = cur;
            root_in = {root_s[g][ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (adv) begin
            vld_ff <= vld_s[g];
         end
         if (adv) begin
            rad_ff  <= rad_in;
            rem_ff  <= rem_in;
            root_ff <= root_in;
            side_ff <= side_s[g];
         end
      end

      assign rad_s[g+1]  = rad_ff;
      assign rem_s[g+1]  = rem_ff;
      assign root_s[g+1] = root_ff;
      assign vld_s[g+1]  = vld_ff;
      assign side_s[g+1] = side_ff;
   end

   assign out_valid = vld_s[ROOT_W];
   assign out_root  = root_s[ROOT_W];
   assign out_side  = side_s[ROOT_W];

endmodule

>>> rtl/phong_recip.sv
module phong_recip
   import phong_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic [ROOT_W-1:0]  in_len,
   input  side_type           in_side,
   output logic               out_valid,
   output logic [RECIP_W-1:0] out_recip,
   output logic               out_zero,
   output side_type           out_side
);

   // 2^32 / len, one quotient bit per stage; only the top dividend bit is set
   logic [ROOT_W:0]    rem_s [0:RECIP_W];
   logic [RECIP_W-1:0] q_s   [0:RECIP_W];
   logic [ROOT_W-1:0]  len_s [0:RECIP_W];
   logic               vld_s [0:RECIP_W];
   side_type           side_s[0:RECIP_W];

   assign rem_s[0]  = '0;
   assign q_s[0]    = '0;
   assign len_s[0]  = in_len;
   assign vld_s[0]  = in_valid;
   assign side_s[0] = in_side;

   for (genvar g = 0; g < RECIP_W; g++) begin : g_stage
      logic [ROOT_W:0]    rem_ff, rem_in, cur;
      logic [RECIP_W-1:0] q_ff, q_in;
      logic [ROOT_W-1:0]  len_ff;
      logic               vld_ff;
      side_type           side_ff;

      always_comb begin
         cur = {rem_s[g][ROOT_W-1:0], (g == 0) ? 1'b1 : 1'b0};
         if (cur >= {1'b0, len_s[g]}) begin
            rem_in = cur - {1'b0, len_s[g]};
            q_in   = {q_s[g][RECIP_W-2:0], 1'b1};
         end else begin
            rem_in = cur;
            q_in   = {q_s[g][RECIP_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (adv) begin
            vld_ff <= vld_s[g];
         end
         if (adv) begin
            rem_ff  <= rem_in;
            q_ff    <= q_in;
            len_ff  <= len_s[g];
            side_ff <= side_s[g];
         end
      end

      assign rem_s[g+1]  = rem_ff;
      assign q_s[g+1]    = q_ff;
      assign len_s[g+1]  = len_ff;
      assign vld_s[g+1]  = vld_ff;
      assign side_s[g+1] = side_ff;
   end

   assign out_valid = vld_s[RECIP_W];
   assign out_recip = q_s[RECIP_W];
   assign out_zero  = (len_s[RECIP_W] == '0);
   assign out_side  = side_s[RECIP_W];

endmodule

>>> rtl/phong_point_light_shader_core.sv
// channel | ports         | direction | handshake
// --------+---------------+-----------+--------------------------------
// request | req_*         | in        | req_valid / req_ready
// result  | rsp_*         | out       | rsp_valid / rsp_ready
// csr     | csr_*         | in        | csr_we, no wait, no read-back
//
// One word enters per cycle unless the pipe stalls; stages run setup, sqrt,
// reciprocal, shading. The bit-per-stage sqrt and divider set the depth.
// Synchronous reset clears valid bits and restores register defaults.
// All stages move together: while the result register holds a word that is
// not taken, the pipe holds still and req_ready is low.
module phong_point_light_shader_core
   import phong_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [COORD_W-1:0]  req_point_x,
   input  logic [COORD_W-1:0]  req_point_y,
   input  logic [COORD_W-1:0]  req_point_z,
   input  logic [DIR_W-1:0]    req_normal_x,
   input  logic [DIR_W-1:0]    req_normal_y,
   input  logic [DIR_W-1:0]    req_normal_z,
   input  logic [DIR_W-1:0]    req_view_x,
   input  logic [DIR_W-1:0]    req_view_y,
   input  logic [DIR_W-1:0]    req_view_z,
   input  logic [COLOR_W-1:0]  req_color_rgb,
   input  logic [7:0]          req_spec_weight,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [CHAN_W-1:0]   rsp_out_red,
   output logic [CHAN_W-1:0]   rsp_out_green,
   output logic [CHAN_W-1:0]   rsp_out_blue,
   input  logic                csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]  csr_wdata
);

   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // ---------------- configuration
   logic [COORD_W-1:0] lx_ff, ly_ff, lz_ff;
   logic [7:0]         amb_ff, dg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lx_ff  <= LIGHT_X_RST;
         ly_ff  <= LIGHT_Y_RST;
         lz_ff  <= LIGHT_Z_RST;
         amb_ff <= AMBIENT_RST;
         dg_ff  <= DIFFUSE_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LIGHT_X: lx_ff  <= csr_wdata;
            CSR_LIGHT_Y: ly_ff  <= csr_wdata;
            CSR_LIGHT_Z: lz_ff  <= csr_wdata;
            CSR_AMBIENT: amb_ff <= csr_wdata[7:0];
            CSR_DIFFUSE: dg_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // ---------------- S0: light vector
   logic [2:0][COORD_W-1:0] lpos, pnt;
   side_type s0_in, s0_ff, s1_ff, s2_ff;
   logic     v0_ff, v1_ff, v2_ff;
   logic [2:0][RAD_W-1:0] sq_in, sq_ff;
   logic [RAD_W-1:0]      lsq_ff;

   assign lpos = {lz_ff, ly_ff, lx_ff};
   assign pnt  = {req_point_z, req_point_y, req_point_x};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s0_in.lv[i] = LV_W'($signed({lpos[i][COORD_W-1], lpos[i]})
                           - $signed({pnt[i][COORD_W-1], pnt[i]}));
         sq_in[i]    = RAD_W'($signed(s0_ff.lv[i]) * $signed(s0_ff.lv[i]));
      end
      s0_in.n   = {req_normal_z, req_normal_y, req_normal_x};
      s0_in.v   = {req_view_z, req_view_y, req_view_x};
      s0_in.rgb = req_color_rgb;
      s0_in.sw  = req_spec_weight;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
      if (adv) begin
         s0_ff  <= s0_in;
         sq_ff  <= sq_in;
         s1_ff  <= s0_ff;
         lsq_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
         s2_ff  <= s1_ff;
      end
   end

   // ---------------- length and reciprocal
   logic               sq_vld, rc_vld, rc_zero;
   logic [ROOT_W-1:0]  len;
   logic [RECIP_W-1:0] recip;
   side_type           sq_side, rc_side;

   phong_sqrt u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (v2_ff),
      .in_radicand (lsq_ff),
      .in_side     (s2_ff),
      .out_valid   (sq_vld),
      .out_root    (len),
      .out_side    (sq_side)
   );

   phong_recip u_recip (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_vld),
      .in_len    (len),
      .in_side   (sq_side),
      .out_valid (rc_vld),
      .out_recip (recip),
      .out_zero  (rc_zero),
      .out_side  (rc_side)
   );

   // ---------------- shading pipe
   localparam int unsigned PH_W  = LV_W + 18;
   localparam int unsigned PL_W  = LV_W + 17;
   localparam int unsigned NLP_W = 32;
   localparam int unsigned NL_W  = 20;
   localparam int unsigned RP_W  = NL_W + DIR_W;
   localparam int unsigned R_W   = 25;
   localparam int unsigned VP_W  = R_W + DIR_W;
   localparam int unsigned S_W   = 15;

   typedef struct packed {
      logic [2:0][DIR_W-1:0] n;
      logic [2:0][DIR_W-1:0] v;
      logic [COLOR_W-1:0]    rgb;
      logic [7:0]            sw;
   } mat_type;

   mat_type m1_mat_ff, m2_mat_ff, d1_mat_ff, d2_mat_ff;
   logic    m1_vld_ff, m2_vld_ff, d1_vld_ff, d2_vld_ff;
   logic    r1_vld_ff, r2_vld_ff, v1_vld_ff, v2_vld_ff;
   logic    m1_zero_ff;
   logic [2:0][PH_W-1:0]  ph_ff, ph_in;
   logic [2:0][PL_W-1:0]  pl_ff, pl_in;
   logic [2:0][DIR_W-1:0] l_m2_ff, l_m2_in, l_d1_ff, l_d2_ff, l_r1_ff;
   logic [2:0][NLP_W-1:0] nlp_ff, nlp_in;
   logic [NL_W-1:0]       nl_d2_ff, nl_d2_in, nl_r1_ff, nl_r2_ff, nl_v1_ff;
   logic [2:0][DIR_W-1:0] v_r1_ff, v_r2_ff;
   logic [2:0][RP_W-1:0]  rp_ff, rp_in;
   logic [2:0][R_W-1:0]   r_ff, r_in;
   logic [2:0][VP_W-1:0]  vp_ff, vp_in;
   logic [COLOR_W-1:0]    rgb_r1_ff, rgb_r2_ff, rgb_v1_ff, rgb_v2_ff;
   logic [7:0]            sw_r1_ff, sw_r2_ff, sw_v1_ff, sw_v2_ff;
   logic [S_W-1:0]        s_v2_ff, s_v2_in, diff_v2_ff, diff_v2_in;

   always_comb begin
      logic signed [63:0] prod, acc;
      for (int i = 0; i < 3; i++) begin
         ph_in[i] = PH_W'($signed(rc_side.lv[i]) * $signed({1'b0, recip[RECIP_W-1:16]}));
         pl_in[i] = PL_W'($signed(rc_side.lv[i]) * $signed({1'b0, recip[15:0]}));
         prod = ($signed(64'($signed(ph_ff[i]))) <<< 16) + 64'($signed(pl_ff[i]));
         l_m2_in[i] = m1_zero_ff ? '0 :
                      DIR_W'(clamp(rnd_shift(prod, 18), -64'sd16384, 64'sd16384));
         nlp_in[i] = NLP_W'($signed(m2_mat_ff.n[i]) * $signed(l_m2_ff[i]));
         rp_in[i]  = RP_W'($signed(nl_d2_ff) * $signed(d2_mat_ff.n[i]));
         r_in[i]   = R_W'(rnd_shift(64'($signed(rp_ff[i])), 13) - 64'($signed(l_r1_ff[i])));
         vp_in[i]  = VP_W'($signed(v_r2_ff[i]) * $signed(r_ff[i]));
      end
      acc = 64'($signed(nlp_ff[0])) + 64'($signed(nlp_ff[1])) + 64'($signed(nlp_ff[2]));
      nl_d2_in = NL_W'(rnd_shift(acc, 14));
      acc = 64'($signed(vp_ff[0])) + 64'($signed(vp_ff[1])) + 64'($signed(vp_ff[2]));
      s_v2_in = S_W'(clamp(rnd_shift(acc, 14), 64'sd0, 64'sd16384));
      diff_v2_in = S_W'(clamp(64'($signed(nl_v1_ff)), 64'sd0, 64'sd16384));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
         m2_vld_ff <= 1'b0;
         d1_vld_ff <= 1'b0;
         d2_vld_ff <= 1'b0;
         r1_vld_ff <= 1'b0;
         r2_vld_ff <= 1'b0;
         v1_vld_ff <= 1'b0;
         v2_vld_ff <= 1'b0;
      end else if (adv) begin
         m1_vld_ff <= rc_vld;
         m2_vld_ff <= m1_vld_ff;
         d1_vld_ff <= m2_vld_ff;
         d2_vld_ff <= d1_vld_ff;
         r1_vld_ff <= d2_vld_ff;
         r2_vld_ff <= r1_vld_ff;
         v1_vld_ff <= r2_vld_ff;
         v2_vld_ff <= v1_vld_ff;
      end
      if (adv) begin
         // M1/M2: unit light direction
         ph_ff      <= ph_in;
         pl_ff      <= pl_in;
         m1_zero_ff <= rc_zero;
         m1_mat_ff  <= '{n: rc_side.n, v: rc_side.v, rgb: rc_side.rgb, sw: rc_side.sw};
         l_m2_ff    <= l_m2_in;
         m2_mat_ff  <= m1_mat_ff;
         // D1/D2: n.l
         nlp_ff     <= nlp_in;
         l_d1_ff    <= l_m2_ff;
         d1_mat_ff  <= m2_mat_ff;
         nl_d2_ff   <= nl_d2_in;
         l_d2_ff    <= l_d1_ff;
         d2_mat_ff  <= d1_mat_ff;
         // R1/R2: reflected direction
         rp_ff      <= rp_in;
         l_r1_ff    <= l_d2_ff;
         nl_r1_ff   <= nl_d2_ff;
         v_r1_ff    <= d2_mat_ff.v;
         rgb_r1_ff  <= d2_mat_ff.rgb;
         sw_r1_ff   <= d2_mat_ff.sw;
         r_ff       <= r_in;
         nl_r2_ff   <= nl_r1_ff;
         v_r2_ff    <= v_r1_ff;
         rgb_r2_ff  <= rgb_r1_ff;
         sw_r2_ff   <= sw_r1_ff;
         // V1/V2: v.r
         vp_ff      <= vp_in;
         nl_v1_ff   <= nl_r2_ff;
         rgb_v1_ff  <= rgb_r2_ff;
         sw_v1_ff   <= sw_r2_ff;
         s_v2_ff    <= s_v2_in;
         diff_v2_ff <= diff_v2_in;
         rgb_v2_ff  <= rgb_v1_ff;
         sw_v2_ff   <= sw_v1_ff;
      end
   end

   // ---------------- s^32 by repeated squaring, one square per stage
   logic [S_W-1:0]     pw_s   [0:SPEC_SQUARINGS];
   logic               pv_s   [0:SPEC_SQUARINGS];
   logic [S_W-1:0]     pd_s   [0:SPEC_SQUARINGS];
   logic [COLOR_W-1:0] prgb_s [0:SPEC_SQUARINGS];
   logic [7:0]         psw_s  [0:SPEC_SQUARINGS];

   assign pw_s[0]   = s_v2_ff;
   assign pv_s[0]   = v2_vld_ff;
   assign pd_s[0]   = diff_v2_ff;
   assign prgb_s[0] = rgb_v2_ff;
   assign psw_s[0]  = sw_v2_ff;

   for (genvar g = 0; g < SPEC_SQUARINGS; g++) begin : g_pow
      logic [2*S_W-1:0]   sq;
      logic [S_W-1:0]     pw_ff, pw_in, pd_ff;
      logic               pv_ff;
      logic [COLOR_W-1:0] prgb_ff;
      logic [7:0]         psw_ff;

      assign sq    = pw_s[g] * pw_s[g];
      assign pw_in = S_W'((sq + (2*S_W)'(ONE_Q14 / 2)) >> 14);

      always_ff @(posedge clock) begin
         if (reset) begin
            pv_ff <= 1'b0;
         end else if (adv) begin
            pv_ff <= pv_s[g];
         end
         if (adv) begin
            pw_ff   <= pw_in;
            pd_ff   <= pd_s[g];
            prgb_ff <= prgb_s[g];
            psw_ff  <= psw_s[g];
         end
      end

      assign pw_s[g+1]   = pw_ff;
      assign pv_s[g+1]   = pv_ff;
      assign pd_s[g+1]   = pd_ff;
      assign prgb_s[g+1] = prgb_ff;
      assign psw_s[g+1]  = psw_ff;
   end

   // ---------------- F1..F3: color mix and saturation
   logic               f1_vld_ff, f2_vld_ff, out_vld_ff;
   logic [2:0][15:0]   ca_f1_ff, ca_f2_ff;
   logic [2:0][22:0]   cd_f1_ff;
   logic [22:0]        ssw_f1_ff, ssw_f2_ff;
   logic [2:0][30:0]   cdd_f2_ff;
   logic [2:0][CHAN_W-1:0] ch_ff, ch_in;
   logic [2:0][7:0]    col;

   always_comb begin
      logic [32:0] sum;
      logic [10:0] ch;
      for (int i = 0; i < 3; i++) begin
         col[i] = prgb_s[SPEC_SQUARINGS][COLOR_W-1-8*i -: 8];
         sum = {3'b0, ca_f2_ff[i], 14'b0} + {2'b0, cdd_f2_ff[i]} + {2'b0, ssw_f2_ff, 8'b0};
         ch  = 11'((sum + 33'(1 << 21)) >> 22);
         ch_in[i] = (ch > 11'd511) ? 9'd511 : ch[CHAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff  <= 1'b0;
         f2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         f1_vld_ff  <= pv_s[SPEC_SQUARINGS];
         f2_vld_ff  <= f1_vld_ff;
         out_vld_ff <= f2_vld_ff;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            ca_f1_ff[i]  <= col[i] * amb_ff;
            cd_f1_ff[i]  <= col[i] * pd_s[SPEC_SQUARINGS];
            cdd_f2_ff[i] <= cd_f1_ff[i] * dg_ff;
         end
         ssw_f1_ff <= pw_s[SPEC_SQUARINGS] * psw_s[SPEC_SQUARINGS];
         ca_f2_ff  <= ca_f1_ff;
         ssw_f2_ff <= ssw_f1_ff;
         ch_ff     <= ch_in;
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_out_red   = ch_ff[0];
   assign rsp_out_green = ch_ff[1];
   assign rsp_out_blue  = ch_ff[2];

endmodule
